FILE: hdl/cpeq_pkg.sv
package cpeq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = 7;
  localparam int TINC_W = 16;
  localparam logic [TINC_W-1:0] TICK_INC_RESET = 16'd20;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_POSITION = 2'd1;
  localparam logic [1:0] CMD_BUTTONS = 2'd2;
  localparam logic [1:0] CMD_POP = 2'd3;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] event_value;
  } req_t;

  typedef struct packed {
    logic               pop_valid;
    logic               pop_kind;
    logic [31:0]        pop_value;
    logic [COUNT_W-1:0] queue_count;
    logic               notify;
    logic               dropped;
    logic [31:0]        elapsed_time;
  } rsp_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
  } entry_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] fill_count(input logic [IDX_W-1:0] w,
                                                  input logic [IDX_W-1:0] r);
    if (w >= r) begin
      return w - r;
    end
    return IDX_W'(QUEUE_DEPTH - int'(r) + int'(w));
  endfunction

endpackage

FILE: hdl/coalescing_pointer_event_queue_unit.sv
// Coalescing pointer event queue.
// req channel (req_valid, req_stall, req): one command per transaction, a tick,
// a position update, a button update or a pop of the oldest queue entry.
// rsp channel (rsp_valid, rsp_stall, rsp): exactly one result per command, in
// command order, with pop data, fill count, notify, dropped flag and time.
// cfg channel (cfg_valid, cfg_ready, cfg_data): writes tick_increment; always
// ready, to be written only while the block is idle.
// Each command is accepted in S_IDLE; S_FIN, S_BTN or S_POPRD then finishes
// the work and loads the result register once free. A tick writes up to two
// entries through the single write port of the entry memory, one per cycle,
// the button entry once S_BTN finds the result register free; a pop reads
// the memory into registered read data; a new command is taken only in S_IDLE.
// The result register holds a result until it is taken; while a held result
// is stalled the block finishes no command and stalls req after the next accept.
// Reset clears indices, latched and reported values, the time counter and
// sets tick_increment to 20; the memory needs no clearing, as only entries
// written since reset are ever read.
module coalescing_pointer_event_queue_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  cpeq_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output cpeq_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cpeq_pkg::TINC_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIN = 2'd1;
  localparam logic [1:0] S_BTN = 2'd2;
  localparam logic [1:0] S_POPRD = 2'd3;

  cpeq_pkg::entry_t mem [cpeq_pkg::QUEUE_DEPTH];
  cpeq_pkg::entry_t rd_data;
  cpeq_pkg::entry_t mem_wdata;
  logic [cpeq_pkg::IDX_W-1:0] mem_waddr;
  logic mem_we;
  logic mem_re;

  logic [1:0] state;
  logic [cpeq_pkg::IDX_W-1:0] w_idx;
  logic [cpeq_pkg::IDX_W-1:0] r_idx;
  logic [31:0] latest_position;
  logic [31:0] reported_position;
  logic [31:0] latest_buttons;
  logic [31:0] reported_buttons;
  logic [31:0] time_counter;
  logic [cpeq_pkg::TINC_W-1:0] tick_inc;
  logic last_move;

  logic tick_pos;
  logic tick_drop;
  logic pop_hit;

  logic accept;
  logic rsp_free;
  logic empty;
  logic full;
  logic pos_changed;
  logic btn_changed;
  logic coalesce;
  logic rsp_load;
  logic [cpeq_pkg::IDX_W-1:0] w_after_btn;
  logic [cpeq_pkg::IDX_W-1:0] r_after_pop;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign empty = (w_idx == r_idx);
  assign full = (cpeq_pkg::next_slot(w_idx) == r_idx);
  assign pos_changed = (latest_position != reported_position);
  assign btn_changed = (latest_buttons != reported_buttons);
  assign coalesce = !empty && last_move;
  assign rsp_load = rsp_free && (state != S_IDLE);
  assign w_after_btn = (btn_changed && !full) ? cpeq_pkg::next_slot(w_idx) : w_idx;
  assign r_after_pop = pop_hit ? cpeq_pkg::next_slot(r_idx) : r_idx;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = w_idx;
    mem_wdata = '{kind: cpeq_pkg::KIND_MOVE, value: latest_position};
    mem_re = 1'b0;
    if (accept && req.command == cpeq_pkg::CMD_TICK && pos_changed) begin
      if (coalesce) begin
        mem_we = 1'b1;
        mem_waddr = cpeq_pkg::prev_slot(w_idx);
      end else if (!full) begin
        mem_we = 1'b1;
      end
    end
    if (state == S_BTN && rsp_free && btn_changed && !full) begin
      mem_we = 1'b1;
      mem_wdata = '{kind: cpeq_pkg::KIND_BUTTON, value: latest_buttons};
    end
    if (accept && req.command == cpeq_pkg::CMD_POP && !empty) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[r_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      w_idx <= '0;
      r_idx <= '0;
      latest_position <= '0;
      reported_position <= '0;
      latest_buttons <= '0;
      reported_buttons <= '0;
      time_counter <= '0;
      tick_inc <= cpeq_pkg::TICK_INC_RESET;
      last_move <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_inc <= cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.command)
              cpeq_pkg::CMD_TICK: begin
                time_counter <= time_counter + 32'(tick_inc);
                if (pos_changed) begin
                  reported_position <= latest_position;
                  if (!coalesce && !full) begin
                    w_idx <= cpeq_pkg::next_slot(w_idx);
                    last_move <= 1'b1;
                  end
                end
                state <= S_BTN;
              end
              cpeq_pkg::CMD_POSITION: begin
                latest_position <= req.event_value;
                state <= S_FIN;
              end
              cpeq_pkg::CMD_BUTTONS: begin
                latest_buttons <= req.event_value;
                state <= S_FIN;
              end
              cpeq_pkg::CMD_POP: begin
                state <= S_POPRD;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_FIN: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        S_BTN: begin
          if (rsp_free) begin
            if (btn_changed) begin
              reported_buttons <= latest_buttons;
              if (!full) begin
                w_idx <= cpeq_pkg::next_slot(w_idx);
                last_move <= 1'b0;
              end
            end
            state <= S_IDLE;
          end
        end
        S_POPRD: begin
          if (rsp_free) begin
            r_idx <= r_after_pop;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick_pos <= pos_changed;
      tick_drop <= pos_changed && !coalesce && full;
      pop_hit <= !empty;
    end
    if (rsp_load) begin
      rsp.pop_valid <= 1'b0;
      rsp.pop_kind <= 1'b0;
      rsp.pop_value <= '0;
      rsp.queue_count <= cpeq_pkg::COUNT_W'(cpeq_pkg::fill_count(w_idx, r_idx));
      rsp.notify <= 1'b0;
      rsp.dropped <= 1'b0;
      rsp.elapsed_time <= time_counter;
      if (state == S_BTN) begin
        rsp.queue_count <= cpeq_pkg::COUNT_W'(cpeq_pkg::fill_count(w_after_btn, r_idx));
        rsp.notify <= tick_pos || btn_changed;
        rsp.dropped <= tick_drop || (btn_changed && full);
      end
      if (state == S_POPRD) begin
        rsp.queue_count <= cpeq_pkg::COUNT_W'(cpeq_pkg::fill_count(w_idx, r_after_pop));
        if (pop_hit) begin
          rsp.pop_valid <= 1'b1;
          rsp.pop_kind <= rd_data.kind;
          rsp.pop_value <= rd_data.value;
        end
      end
    end
  end

  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) != S_IDLE)
    else $error("result appeared without a command in progress");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (int'(w_idx) < cpeq_pkg::QUEUE_DEPTH) && (int'(r_idx) < cpeq_pkg::QUEUE_DEPTH))
    else $error("ring index out of range");

  a_pop_no_tick_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pop_valid |-> !rsp.notify && !rsp.dropped)
    else $error("pop result carries tick flags");

  a_drop_needs_notify: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped |-> rsp.notify)
    else $error("dropped without notify");

  a_no_write_on_pop: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_POPRD) && (state != S_FIN))
    else $error("memory write outside a tick");

endmodule
